FILE: src/ompl_pkg.sv
// Shared types, constants and helper functions of the online makespan job placer.
`timescale 1ns / 1ps

package ompl_pkg;

  localparam int LOAD_W     = 48;
  localparam int MACH_N     = 16;
  localparam int ID_W       = 4;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 52;
  localparam int COEF_W     = 20;
  localparam int PROD_W     = 72;
  localparam int MUL_DIGITS = 5;
  localparam int POLICY_W   = 2;
  localparam int BY_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic [POLICY_W-1:0] POL_GREEDY = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BARTAL = 2'd1;
  localparam logic [POLICY_W-1:0] POL_KARGER = 2'd2;
  localparam logic [POLICY_W-1:0] POL_ALBERS = 2'd3;

  localparam logic [BY_W-1:0] BY_LEAST = 2'd0;
  localparam logic [BY_W-1:0] BY_RULE  = 2'd1;
  localparam logic [BY_W-1:0] BY_DELAY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MACHINES = 1'b1;

  localparam logic [CNT_W-1:0] M_MIN = 5'd3;
  localparam logic [CNT_W-1:0] M_MAX = 5'd16;

  // Q2.16 thresholds
  localparam logic [COEF_W-1:0] K_BARTAL = 20'd130154;
  localparam logic [COEF_W-1:0] K_KARGER = 20'd127468;
  localparam logic [COEF_W-1:0] K_ALBERS = 20'd126026;
  localparam logic [23:0]       ALB_UNIT = 24'd120980;
  localparam logic [23:0]       K_029    = 24'd19005;

  typedef struct packed {
    logic              mode;
    logic [LOAD_W-1:0] amount;
    logic [ID_W-1:0]   target_machine;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   machine;
    logic [BY_W-1:0]   placed_by;
    logic [LOAD_W-1:0] machine_load;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  a;
    logic [COEF_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [LOAD_W-1:0] load;
    logic [ID_W-1:0]   id;
  } tbl_wr_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

  // floor(0.445 * m)
  function automatic logic [CNT_W-1:0] bartal_pos(input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] r;
    case (m)
      5'd3, 5'd4:          r = 5'd1;
      5'd5, 5'd6:          r = 5'd2;
      5'd7, 5'd8:          r = 5'd3;
      5'd9, 5'd10, 5'd11:  r = 5'd4;
      5'd12, 5'd13:        r = 5'd5;
      5'd14, 5'd15:        r = 5'd6;
      5'd16:               r = 5'd7;
      default:             r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] alb_coef_a(input logic [CNT_W-1:0] m);
    logic [23:0] rest;
    logic [23:0] p;
    rest = 24'(m - (m >> 1));
    p    = ALB_UNIT * rest;
    return p[COEF_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] alb_coef_b(input logic [CNT_W-1:0] m);
    logic [23:0] p;
    logic [23:0] q;
    logic [23:0] d;
    p = ALB_UNIT * 24'(m >> 1);
    q = K_029 * 24'(m);
    d = p - q;
    return (p > q) ? d[COEF_W-1:0] : '0;
  endfunction

endpackage

FILE: src/online_makespan_job_placer.sv
// Top level of the online makespan job placer: sequencer, table and shared multiplier.
`timescale 1ns / 1ps

// Usage:
//   job channel (job_valid / job_stall / job): one request per job placement
//   (mode 0) or machine delay (mode 1). job_stall is high while a request is
//   being worked on; only one request is in flight.
//   result channel (result_valid / result_stall / result): one result per
//   request. The result register holds while result_stall is high; the next
//   request is still taken meanwhile, and its result waits until the
//   register frees up.
//   cfg port (cfg_write / cfg_index / cfg_data): index 0 policy, 1 machine
//   count; write only while idle.
// Steps: an accept state, a scan of the table slots (one per cycle, held
//   while a test waits on the multiplier) that stops at the last machine in
//   use, a search for the chosen machine (one slot per cycle), a bubble pass
//   to restore the order, and the load of the result register. A delay skips
//   the scan; one for a machine not in use goes straight to the result.
//   Bartal adds one test (two products on the shared multiplier), Albers two
//   or four products, Karger one test per machine in use after the first.
// Reset: all loads zero, slot k holds machine k, policy greedy, 16 machines.
module online_makespan_job_placer import ompl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_stall,
  input  job_t                  job,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_TST2   = 4'd2;
  localparam logic [3:0] S_TST3   = 4'd3;
  localparam logic [3:0] S_ALB1   = 4'd4;
  localparam logic [3:0] S_ALB2   = 4'd5;
  localparam logic [3:0] S_ALB3   = 4'd6;
  localparam logic [3:0] S_ALB4   = 4'd7;
  localparam logic [3:0] S_ALB5   = 4'd8;
  localparam logic [3:0] S_FIND   = 4'd9;
  localparam logic [3:0] S_BUBBLE = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_MWAIT  = 4'd12;

  logic [3:0] state;
  logic [3:0] ret;

  // configuration
  logic [POLICY_W-1:0] policy;
  logic [CNT_W-1:0]    mcount;

  // request being worked on
  logic              mode_q;
  logic [LOAD_W-1:0] job_q;
  logic [ID_W-1:0]   target_q;

  // scan bookkeeping
  logic [POS_W-1:0]  k;
  logic [POS_W-1:0]  n;
  logic [SUM_W-1:0]  prefix;
  logic [SUM_W-1:0]  pre_half;
  logic [LOAD_W-1:0] h0;
  logic [LOAD_W-1:0] h_half;
  logic [LOAD_W-1:0] h_last;
  logic [LOAD_W-1:0] h_cur;
  logic [ID_W-1:0]   id_cur;
  logic [ID_W-1:0]   id_half;
  logic [ID_W-1:0]   cid;
  logic [BY_W-1:0]   cby;

  // placement and result
  logic [POS_W-1:0]  p;
  logic [LOAD_W-1:0] cur_load;
  result_t           res_q;

  // shared multiplier
  mul_req_t          mreq;
  logic              mul_done;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] p0;
  logic [PROD_W-1:0] p1;

  // table
  logic [POS_W-1:0]  rd_addr;
  logic [LOAD_W-1:0] rd_load;
  logic [ID_W-1:0]   rd_id;
  tbl_wr_t           twr;

  ompl_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_load (rd_load),
    .rd_id   (rd_id),
    .wr      (twr)
  );

  ompl_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_p)
  );

  // Machine count clamped to the supported range.
  logic [CNT_W-1:0] m;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] l_pos;
  logic [CNT_W-1:0] n_ext;

  always_comb begin
    if (mcount < M_MIN) begin
      m = M_MIN;
    end else if (mcount > M_MAX) begin
      m = M_MAX;
    end else begin
      m = mcount;
    end
  end

  assign half  = m >> 1;
  assign l_pos = bartal_pos(m);
  assign n_ext = {1'b0, n};

  // Scan-side decode
  logic              active;
  logic              need_test;
  logic              last_active;
  logic              adv;
  logic [LOAD_W-1:0] adv_load;
  logic [ID_W-1:0]   adv_id;
  logic [LOAD_W-1:0] x_scan;
  logic              test_pass;

  assign active      = ({1'b0, rd_id} < m);
  assign x_scan      = sat_add(rd_load, job_q);
  assign need_test   = active && (((policy == POL_KARGER) && (n != '0)) ||
                                  ((policy == POL_BARTAL) && (n_ext == l_pos)));
  assign last_active = (n_ext == m - 5'd1);
  assign adv         = ((state == S_SCAN) && active && !need_test) || (state == S_TST3);
  assign adv_load    = (state == S_TST3) ? h_cur : rd_load;
  assign adv_id      = (state == S_TST3) ? id_cur : rd_id;
  // (h + j) * i * 2^16 <= K * sum of the lower loads
  assign test_pass   = ({p0[PROD_W-17:0], 16'b0} <= p1);

  // Albers sums: the job lands on the least loaded machine, re-sorted.
  logic [LOAD_W-1:0] x0;
  logic [LOAD_W-1:0] low_pick;
  logic [LOAD_W-1:0] x_half;
  logic [SUM_W-1:0]  ll;
  logic [SUM_W-1:0]  tot;
  logic [SUM_W-1:0]  lh;

  assign x0       = sat_add(h0, job_q);
  assign low_pick = (x0 <= h_half) ? x0 : h_half;
  assign ll       = pre_half - SUM_W'(h0) + SUM_W'(low_pick);
  assign tot      = prefix - SUM_W'(h0) + SUM_W'(x0);
  assign lh       = tot - ll;
  assign x_half   = sat_add(h_half, job_q);

  // Placement: find the machine, then bubble it upward to its sorted slot.
  logic [ID_W-1:0] find_id;
  logic            move_down;

  assign find_id   = mode_q ? target_q : cid;
  assign rd_addr   = (state == S_BUBBLE) ? p + POS_W'(1) : k;
  assign move_down = (p != POS_W'(MACH_N - 1)) &&
                     ((rd_load < cur_load) || ((rd_load == cur_load) && (rd_id < find_id)));

  always_comb begin
    twr.en   = (state == S_BUBBLE);
    twr.addr = p;
    twr.load = move_down ? rd_load : cur_load;
    twr.id   = move_down ? rd_id : find_id;
  end

  assign job_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      policy       <= POL_GREEDY;
      mcount       <= M_MAX;
      result_valid <= 1'b0;
      mreq.start   <= 1'b0;
      k            <= '0;
      n            <= '0;
    end else begin
      mreq.start <= 1'b0;

      // Drop valid once taken, unless a new result is loaded this cycle.
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_POLICY:   policy <= cfg_data[POLICY_W-1:0];
          REG_MACHINES: mcount <= cfg_data;
          default:      ;
        endcase
      end

      // Fold an active slot into the running sums.
      if (adv) begin
        prefix <= prefix + SUM_W'(adv_load);
        h_last <= adv_load;
        if (n == '0) begin
          h0  <= adv_load;
          cid <= adv_id;
          cby <= BY_LEAST;
        end
        if (n_ext == half) begin
          h_half   <= adv_load;
          id_half  <= adv_id;
          pre_half <= prefix;
        end
        n <= n + POS_W'(1);
        if (last_active) begin
          k     <= '0;
          state <= (policy == POL_ALBERS) ? S_ALB1 : S_FIND;
        end else begin
          k     <= k + POS_W'(1);
          state <= S_SCAN;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            mode_q   <= job.mode;
            job_q    <= job.amount;
            target_q <= job.target_machine;
            k        <= '0;
            n        <= '0;
            prefix   <= '0;
            if (!job.mode) begin
              state <= S_SCAN;
            end else if ({1'b0, job.target_machine} < m) begin
              state <= S_FIND;
            end else begin
              // delay for a machine not in use: report and drop
              res_q.machine      <= job.target_machine;
              res_q.placed_by    <= BY_DELAY;
              res_q.machine_load <= '0;
              state              <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (!active) begin
            k <= k + POS_W'(1);
          end else if (need_test) begin
            h_cur      <= rd_load;
            id_cur     <= rd_id;
            mreq.start <= 1'b1;
            mreq.a     <= SUM_W'(x_scan);
            mreq.b     <= COEF_W'(n);
            ret        <= S_TST2;
            state      <= S_MWAIT;
          end
        end
        S_TST2: begin
          mreq.start <= 1'b1;
          mreq.a     <= prefix;
          mreq.b     <= (policy == POL_BARTAL) ? K_BARTAL : K_KARGER;
          ret        <= S_TST3;
          state      <= S_MWAIT;
        end
        S_TST3: begin
          if (test_pass) begin
            cid <= id_cur;
            cby <= BY_RULE;
          end
        end
        S_ALB1: begin
          mreq.start <= 1'b1;
          mreq.a     <= ll;
          mreq.b     <= alb_coef_a(m);
          ret        <= S_ALB2;
          state      <= S_MWAIT;
        end
        S_ALB2: begin
          mreq.start <= 1'b1;
          mreq.a     <= lh;
          mreq.b     <= alb_coef_b(m);
          ret        <= S_ALB3;
          state      <= S_MWAIT;
        end
        S_ALB3: begin
          if (p0 <= p1) begin
            // rule one: keep the least loaded machine
            state <= S_FIND;
          end else if (x_half > h_last) begin
            mreq.start <= 1'b1;
            mreq.a     <= SUM_W'(x_half);
            mreq.b     <= COEF_W'(m);
            ret        <= S_ALB4;
            state      <= S_MWAIT;
          end else begin
            cid   <= id_half;
            cby   <= BY_RULE;
            state <= S_FIND;
          end
        end
        S_ALB4: begin
          mreq.start <= 1'b1;
          mreq.a     <= tot;
          mreq.b     <= K_ALBERS;
          ret        <= S_ALB5;
          state      <= S_MWAIT;
        end
        S_ALB5: begin
          if (!({p0[PROD_W-17:0], 16'b0} > p1)) begin
            cid <= id_half;
            cby <= BY_RULE;
          end
          state <= S_FIND;
        end
        S_MWAIT: begin
          if (mul_done) begin
            p1    <= mul_p;
            p0    <= p1;
            state <= ret;
          end
        end
        S_FIND: begin
          if (rd_id == find_id) begin
            cur_load <= sat_add(rd_load, job_q);
            p        <= k;
            state    <= S_BUBBLE;
          end else begin
            k <= k + POS_W'(1);
          end
        end
        S_BUBBLE: begin
          if (move_down) begin
            p <= p + POS_W'(1);
          end else begin
            res_q.machine      <= find_id;
            res_q.placed_by    <= mode_q ? BY_DELAY : cby;
            res_q.machine_load <= cur_load;
            state              <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (!result_valid || !result_stall) begin
            result       <= res_q;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MWAIT))
    else $error("multiplier finished outside a wait state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (n_ext < m))
    else $error("scan ran past the active machines");

  a_write_in_bubble: assert property (@(posedge clk) disable iff (rst)
    twr.en |=> ($past(state) == S_BUBBLE))
    else $error("table written outside the bubble pass");

  a_result_after_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_OUT))
    else $error("result raised without a finished request");
`endif

endmodule

FILE: src/ompl_mul.sv
// Shared radix-16 shift-add multiplier, one digit of the short operand per cycle.
`timescale 1ns / 1ps

module ompl_mul import ompl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] a_sh;
  logic [COEF_W-1:0] b_rem;
  logic [2:0]        cnt;
  logic              busy;
  logic [PROD_W-1:0] pp;

  always_comb begin
    pp = (b_rem[0] ? a_sh : '0)
       + (b_rem[1] ? (a_sh << 1) : '0)
       + (b_rem[2] ? (a_sh << 2) : '0)
       + (b_rem[3] ? (a_sh << 3) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        prod  <= '0;
        a_sh  <= PROD_W'(req.a);
        b_rem <= req.b;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        prod  <= prod + pp;
        a_sh  <= a_sh << 4;
        b_rem <= b_rem >> 4;
        cnt   <= cnt + 3'd1;
        if (cnt == 3'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/ompl_table.sv
// Sorted load table: one load and machine id per slot, one read and one write port.
`timescale 1ns / 1ps

module ompl_table import ompl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [POS_W-1:0]  rd_addr,
  output logic [LOAD_W-1:0] rd_load,
  output logic [ID_W-1:0]   rd_id,
  input  tbl_wr_t           wr
);

  logic [LOAD_W-1:0] loads [MACH_N];
  logic [ID_W-1:0]   ids   [MACH_N];

  assign rd_load = loads[rd_addr];
  assign rd_id   = ids[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MACH_N; k++) begin
        loads[k] <= '0;
        ids[k]   <= ID_W'(k);
      end
    end else if (wr.en) begin
      loads[wr.addr] <= wr.load;
      ids[wr.addr]   <= wr.id;
    end
  end

endmodule

FILE: tb/placer_checker.sv
// Checker for the job placer: predicts each result from the accepted requests and compares.
`timescale 1ns / 1ps

module placer_checker import ompl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  logic                  job_stall,
  input  job_t                  job,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef logic [95:0] wide_t;

  logic [LOAD_W-1:0] loads [MACH_N];
  logic [ID_W-1:0]   ids   [MACH_N];
  logic [POLICY_W-1:0] cur_policy;
  logic [CNT_W-1:0]    cur_count;
  result_t expected_q [$];

  function automatic logic [LOAD_W-1:0] clip_add(logic [LOAD_W-1:0] a, logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

  // Add v to machine mid and bubble it up to keep the order.
  task automatic load_machine(input int mid, input logic [LOAD_W-1:0] v,
                              output logic [LOAD_W-1:0] nl);
    int p;
    logic [LOAD_W-1:0] tl;
    logic [ID_W-1:0] ti;
    p = 0;
    while (p < MACH_N && ids[p] != mid) p++;
    nl = clip_add(loads[p], v);
    loads[p] = nl;
    while (p + 1 < MACH_N && (loads[p+1] < loads[p] ||
           (loads[p+1] == loads[p] && ids[p+1] < ids[p]))) begin
      tl = loads[p]; ti = ids[p];
      loads[p] = loads[p+1]; ids[p] = ids[p+1];
      loads[p+1] = tl; ids[p+1] = ti;
      p++;
    end
  endtask

  task automatic place_request(input job_t rq, output result_t r);
    logic [LOAD_W-1:0] h [MACH_N];
    logic [LOAD_W-1:0] t [MACH_N];
    logic [ID_W-1:0] hid [MACH_N];
    logic [LOAD_W-1:0] tmp, x, nl;
    wide_t s, ll, lh, tot, coef_a, coef_b;
    int m, n, c, lpos, half;
    logic [BY_W-1:0] by;
    m = cur_count < 3 ? 3 : (cur_count > MACH_N ? MACH_N : cur_count);
    r = '0;
    if (rq.mode) begin
      r.machine = rq.target_machine;
      r.placed_by = BY_DELAY;
      if (rq.target_machine < m) begin
        load_machine(rq.target_machine, rq.amount, nl);
        r.machine_load = nl;
      end
      return;
    end
    n = 0;
    for (int k = 0; k < MACH_N; k++)
      if (ids[k] < m && n < m) begin
        h[n] = loads[k]; hid[n] = ids[k]; n++;
      end
    c = 0;
    by = BY_LEAST;
    case (cur_policy)
      POL_BARTAL: begin
        lpos = (m * 445) / 1000;
        s = '0;
        for (int k = 0; k < lpos; k++) s += h[k];
        if (wide_t'(clip_add(h[lpos], rq.amount)) * lpos * 65536 <= s * 130154) begin
          c = lpos; by = BY_RULE;
        end
      end
      POL_KARGER: begin
        for (int i = m - 1; i > 0; i--) begin
          s = '0;
          for (int k = 0; k < i; k++) s += h[k];
          if (wide_t'(clip_add(h[i], rq.amount)) * i * 65536 <= s * 127468) begin
            c = i; by = BY_RULE;
            break;
          end
        end
      end
      POL_ALBERS: begin
        half = m / 2;
        for (int k = 0; k < m; k++) t[k] = h[k];
        t[0] = clip_add(h[0], rq.amount);
        for (int k = 0; k + 1 < m && t[k+1] < t[k]; k++) begin
          tmp = t[k]; t[k] = t[k+1]; t[k+1] = tmp;
        end
        ll = '0; lh = '0; tot = '0;
        for (int k = 0; k < m; k++) begin
          if (k < half) ll += t[k];
          else lh += t[k];
          tot += t[k];
        end
        coef_a = wide_t'(120980) * (m - half);
        coef_b = wide_t'(120980) * half;
        coef_b = coef_b > wide_t'(19005) * m ? coef_b - wide_t'(19005) * m : '0;
        x = clip_add(h[half], rq.amount);
        if (ll * coef_a <= lh * coef_b) c = 0;
        else if (x > h[m-1] && wide_t'(x) * m * 65536 > tot * 126026) c = 0;
        else begin
          c = half; by = BY_RULE;
        end
      end
      default: c = 0;
    endcase
    r.machine = hid[c];
    r.placed_by = by;
    load_machine(hid[c], rq.amount, nl);
    r.machine_load = nl;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t e, got;
    if (rst) begin
      cur_policy <= POL_GREEDY;
      cur_count <= M_MAX;
      for (int k = 0; k < MACH_N; k++) begin
        loads[k] = '0;
        ids[k] = ID_W'(k);
      end
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_POLICY) cur_policy <= cfg_data[POLICY_W-1:0];
        else if (cfg_index == REG_MACHINES) cur_count <= cfg_data;
      end
      if (job_valid && !job_stall) begin
        place_request(job, e);
        expected_q.insert(expected_q.size(), e);
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (got.machine !== e.machine || got.placed_by !== e.placed_by ||
              got.machine_load !== e.machine_load) begin
            $display("%0t: mismatch, expected machine %0d by %0d load %0d, actual %0d %0d %0d",
                     $time, e.machine, e.placed_by, e.machine_load,
                     got.machine, got.placed_by, got.machine_load);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench top of the job placer: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps

module testbench;
  import ompl_pkg::*;

  localparam int STALL_LIMIT = 5000;  // idle cycles before the watchdog fires
  localparam int SETTLE      = 80;    // cycles after the last result

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic job_valid = 1'b0;
  logic job_stall;
  job_t job = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending;

  int tx_pct = 0;         // chance in percent that the sender idles per request
  int rx_pct = 0;         // chance in percent that the receiver stalls per cycle
  int hold_asked = 0;     // long receiver holds requested by the stimulus
  int hold_served = 0;

  online_makespan_job_placer dut (
    .clk, .rst, .job_valid, .job_stall, .job,
    .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  placer_checker chk (
    .clk, .rst, .job_valid, .job_stall, .job,
    .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold counted here when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Watchdog: count cycles in which nothing moves.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || cfg_write || (job_valid && !job_stall) || (result_valid && !result_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one request; idle first at random, keep valid high back to back.
  task automatic send_request(input job_t rq);
    int gap;
    gap = ($urandom_range(99) < tx_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      job_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job_valid <= 1'b1;
    job <= rq;
    @(posedge clk);
    while (job_stall) @(posedge clk);
  endtask

  task automatic send(input logic mode, input logic [LOAD_W-1:0] amt, input int tgt);
    job_t rq;
    rq.mode = mode;
    rq.amount = amt;
    rq.target_machine = ID_W'(tgt);
    send_request(rq);
  endtask

  // Drop valid and wait until every result is back, then let the block settle.
  task automatic drain();
    job_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pol, input logic [CFG_DATA_W-1:0] cnt);
    drain();
    write_reg(REG_POLICY, pol);
    write_reg(REG_MACHINES, cnt);
  endtask

  // Random request: mostly jobs with modest lengths so the rules compete.
  function automatic job_t random_request();
    job_t rq;
    int pick;
    rq.mode = ($urandom_range(99) < 15);
    rq.target_machine = ID_W'($urandom_range(15));
    pick = $urandom_range(199);
    if (pick < 120) rq.amount = LOAD_W'($urandom_range(1000));
    else if (pick < 190) rq.amount = LOAD_W'($urandom_range(1 << 20));
    else if (pick < 198) rq.amount = LOAD_W'({$urandom, $urandom} & 64'h0000_3FFF_FFFF);
    else rq.amount = LOAD_W'({$urandom, $urandom});
    return rq;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] counts [6] = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd7, 5'd11};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every policy, empty and full lengths, delays, saturation.
    send(1'b0, '0, 0);
    send(1'b0, 48'd5, 0);
    send(1'b0, 48'd5, 0);
    send(1'b1, 48'd7, 3);
    send(1'b1, LOAD_MAX, 15);
    send(1'b1, 48'd1, 15);
    configure(5'd4, 5'd2);        // policy wraps to greedy, count acts as three
    send(1'b1, 48'd9, 9);         // delay of a machine not in use
    send(1'b0, 48'd100, 0);
    send(1'b0, 48'd3, 0);
    configure(CFG_DATA_W'(POL_BARTAL), 5'd31); // count acts as sixteen
    send(1'b0, 48'd1, 0);
    send(1'b0, 48'd50, 0);
    send(1'b0, 48'hFFFF_FFFF_FFFE, 5);
    configure(CFG_DATA_W'(POL_KARGER), 5'd5);
    send(1'b0, 48'd10, 0);
    send(1'b0, 48'd1000, 0);
    send(1'b0, 48'd2, 0);
    configure(CFG_DATA_W'(POL_ALBERS), 5'd4);
    send(1'b0, 48'd20, 0);
    send(1'b0, 48'd1, 0);
    send(1'b0, 48'h8000_0000_0000, 0);
    send(1'b1, 48'd300, 2);

    // Random phases: three idle patterns, several settings in each.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin tx_pct = 37; rx_pct = 51; end
        1: begin tx_pct = 51; rx_pct = 37; end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      configure(CFG_DATA_W'($urandom_range(3)),
                (phase < 6) ? counts[phase] : CFG_DATA_W'($urandom_range(31)));
      if (phase == 4) hold_asked = hold_asked + 1;  // block fills while the sender goes on
      for (int n = 0; n < 92; n++) begin
        send_request(random_request());
        if (phase == 7 && n == 40) drain();          // sender pauses for all results
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
